FILE: hdl/scpa_pkg.sv
// ----------------------------------------------------------------------------
// scpa_pkg: shared types and codes of the size-class pool allocator
// Request kinds, result status codes and the sequencer state type.
// ----------------------------------------------------------------------------
package scpa_pkg;

  // Request kinds
  localparam logic [1:0] KIND_ALLOC = 2'd0;
  localparam logic [1:0] KIND_FREE  = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;
  localparam logic [1:0] KIND_NONE  = 2'd3;

  // Result status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_TOO_LARGE = 2'd1;
  localparam logic [1:0] STAT_NO_MEMORY = 2'd2;
  localparam logic [1:0] STAT_BAD_FREE  = 2'd3;

  // Field widths of the configuration port and of the class shift amount
  localparam int unsigned BLK_LOG2_W = 5;
  localparam int unsigned CLS_SH_W   = 6;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

endpackage

FILE: hdl/size_class_pool_allocator.sv
// ----------------------------------------------------------------------------
// size_class_pool_allocator: power-of-two size-class pool allocator
// Bump allocation over equal arena blocks with one free list per class.
// ----------------------------------------------------------------------------
// Every request passes through ST_IDLE and ST_EXEC: in ST_IDLE the request is taken and the
// link and class memories are read (synchronous read), in ST_EXEC, once the result
// register is free, the free list head, the link or class entry and the bump pointer
// are written back and the result is loaded into the output register. The next
// request is taken in the cycle after that, while the result register may still hold
// its beat. The link and class memories have no reset and need no clearing pass:
// the lists only ever reference entries that were written first. A write of the
// block size register empties the pool, as does a pool reset request.
module size_class_pool_allocator
  import scpa_pkg::*;
#(
  parameter int unsigned ARENA_BYTES  = 65536,
  parameter int unsigned NUM_CLASSES  = 14,
  parameter int unsigned HEADER_BYTES = 8,
  parameter int unsigned GRANULE_LOG2 = 3
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,

  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [BLK_LOG2_W-1:0] cfg_block_size_log2_i,

  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [1:0]            kind_i,
  input  logic [15:0]           req_size_i,
  input  logic [15:0]           chunk_address_i,

  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [15:0]           data_address_o,
  output logic [16:0]           chunk_bytes_o,
  output logic [1:0]            status_o
);

  // Derived sizes
  localparam int unsigned AW        = $clog2(ARENA_BYTES + 1);
  localparam int unsigned GRANULES  = ARENA_BYTES >> GRANULE_LOG2;
  localparam int unsigned GW        = $clog2(GRANULES);
  localparam int unsigned CW        = $clog2(NUM_CLASSES);
  localparam int unsigned AFL       = AW - 1;
  localparam int unsigned CLS_LIM   = NUM_CLASSES - 1 + GRANULE_LOG2;
  localparam int unsigned EFF_A     = (AFL < 16) ? AFL : 16;
  localparam int unsigned EFF_MAX   = (CLS_LIM < EFF_A) ? CLS_LIM : EFF_A;
  localparam int unsigned EFF_MIN   = (EFF_MAX < 6) ? EFF_MAX : 6;
  localparam int unsigned BL_RESET  = (EFF_MAX < 13) ? EFF_MAX : 13;
  localparam int unsigned OFF_W     = EFF_MAX + 1;
  localparam int unsigned NBLK_MAX  = ARENA_BYTES >> EFF_MIN;
  localparam int unsigned BLKW      = (NBLK_MAX > 1) ? $clog2(NBLK_MAX) : 1;
  localparam int unsigned XW_A      = (AW > GW + GRANULE_LOG2) ? AW : GW + GRANULE_LOG2;
  localparam int unsigned XW        = ((XW_A > 17) ? XW_A : 17) + 1;
  localparam int unsigned LW        = GW + 1;

  // Sequencer and request registers
  state_e                state_q, state_d;
  logic [1:0]            kind_q;
  logic                  too_large_q;
  logic [CW-1:0]         cls_q;
  logic                  bad_q;
  logic [15:0]           addr_q;
  logic [GW-1:0]         gran_q;
  logic                  hd_v_q;
  logic [GW-1:0]         hd_idx_q;

  // Pool state
  logic [BLK_LOG2_W-1:0] bl_q;
  logic [BLKW-1:0]       cur_blk_q, cur_blk_d;
  logic [OFF_W-1:0]      bump_q, bump_d;
  logic                  head_v_q   [NUM_CLASSES];
  logic [GW-1:0]         head_idx_q [NUM_CLASSES];

  // Memories: link entry is {more valid, next granule}
  logic [LW-1:0]         link_mem  [GRANULES];
  logic [CW-1:0]         class_mem [GRANULES];
  logic [LW-1:0]         link_rd_q;
  logic [CW-1:0]         class_rd_q;

  // Output register
  logic                  out_valid_q;
  logic [15:0]           out_addr_q;
  logic [16:0]           out_bytes_q;
  logic [1:0]            out_status_q;

  logic                  accept;
  logic                  exec_go;
  logic                  out_free;
  logic                  pool_clear;

  // Accept-stage signals
  logic [16:0]           total;
  logic [16:0]           vgran;
  logic [4:0]            vlen;
  logic [CW-1:0]         cls_now;
  logic                  too_large_now;
  logic [XW-1:0]         start_f;
  logic [XW-1:0]         used_end;
  logic                  bad_now;
  logic [GW-1:0]         gran_now;

  // Head read port
  logic [CW-1:0]         cls_e;
  logic [CW-1:0]         hd_sel;
  logic                  hd_v_rd;
  logic [GW-1:0]         hd_idx_rd;

  // Execute-stage signals
  logic [OFF_W-1:0]      bsize;
  logic [CLS_SH_W-1:0]   cls_sh;
  logic [OFF_W-1:0]      csize;
  logic [16:0]           cbytes;
  logic                  need_blk;
  logic                  oom;
  logic [XW-1:0]         nblocks;
  logic [BLKW-1:0]       blk_sel;
  logic [OFF_W-1:0]      off_sel;
  logic [XW-1:0]         start_b;
  logic [XW-1:0]         start_a;
  logic [GW-1:0]         gran_a;
  logic                  free_bad_cls;
  logic                  link_we;
  logic                  class_we;
  logic                  head_pop;
  logic                  head_push;
  logic [15:0]           res_addr;
  logic [16:0]           res_bytes;
  logic [1:0]            res_status;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign exec_go     = (state_q == ST_EXEC) && out_free;

  // Sequencer: take a request, then finish it once the result register frees
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (exec_go) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Size class of an allocate: bit length of the granule count minus one
  always_comb begin
    total = 17'(req_size_i) + 17'(HEADER_BYTES);
    vgran = (total - 17'd1) >> GRANULE_LOG2;
    vlen  = '0;
    for (int i = 0; i < 17; i++) begin
      if (vgran[i]) vlen = 5'(i + 1);
    end
    cls_now       = vlen[CW-1:0];
    too_large_now = (18'(total) > (18'd1 << bl_q));
  end

  // Free checks against the header, granule alignment and the bump end
  always_comb begin
    start_f  = XW'(chunk_address_i) - XW'(HEADER_BYTES);
    used_end = (XW'(cur_blk_q) << bl_q) + XW'(bump_q);
    bad_now  = (chunk_address_i < 16'(HEADER_BYTES))
            || (start_f[GRANULE_LOG2-1:0] != '0)
            || (start_f >= used_end);
    gran_now = start_f[GW+GRANULE_LOG2-1:GRANULE_LOG2];
  end

  // Single read port on the head table
  assign cls_e     = (kind_q == KIND_ALLOC) ? cls_q : class_rd_q;
  assign hd_sel    = (state_q == ST_EXEC) ? cls_e : cls_now;
  assign hd_v_rd   = head_v_q[hd_sel];
  assign hd_idx_rd = head_idx_q[hd_sel];

  // Latch the request
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q      <= kind_i;
      too_large_q <= too_large_now;
      cls_q       <= cls_now;
      bad_q       <= bad_now;
      addr_q      <= chunk_address_i;
      gran_q      <= gran_now;
      hd_v_q      <= hd_v_rd;
      hd_idx_q    <= hd_idx_rd;
    end
  end

  // Memories: read at accept, write back at execute
  always_ff @(posedge clk_i) begin
    if (accept) begin
      link_rd_q  <= link_mem[hd_idx_rd];
      class_rd_q <= class_mem[gran_now];
    end
    if (link_we) begin
      link_mem[gran_q] <= {hd_v_rd, hd_idx_rd};
    end
    if (class_we) begin
      class_mem[gran_a] <= cls_q;
    end
  end

  // Allocate and free arithmetic
  always_comb begin
    bsize        = OFF_W'(1) << bl_q;
    cls_sh       = CLS_SH_W'(cls_e) + CLS_SH_W'(GRANULE_LOG2);
    csize        = OFF_W'(1) << cls_sh;
    cbytes       = 17'd1 << cls_sh;
    need_blk     = ({1'b0, bump_q} + {1'b0, csize}) > {1'b0, bsize};
    nblocks      = XW'(ARENA_BYTES) >> bl_q;
    oom          = need_blk && ((XW'(cur_blk_q) + XW'(1)) >= nblocks);
    blk_sel      = need_blk ? cur_blk_q + BLKW'(1) : cur_blk_q;
    off_sel      = need_blk ? '0 : bump_q;
    start_b      = (XW'(blk_sel) << bl_q) + XW'(off_sel);
    start_a      = hd_v_q ? (XW'(hd_idx_q) << GRANULE_LOG2) : start_b;
    gran_a       = start_a[GW+GRANULE_LOG2-1:GRANULE_LOG2];
    free_bad_cls = ({1'b0, class_rd_q} >= (CW+1)'(NUM_CLASSES));
  end

  // Result and write-back decode
  always_comb begin
    link_we    = 1'b0;
    class_we   = 1'b0;
    head_pop   = 1'b0;
    head_push  = 1'b0;
    pool_clear = 1'b0;
    cur_blk_d  = cur_blk_q;
    bump_d     = bump_q;
    res_addr   = '0;
    res_bytes  = '0;
    res_status = STAT_OK;
    unique case (kind_q)
      KIND_ALLOC: begin
        if (too_large_q) begin
          res_status = STAT_TOO_LARGE;
        end else if (!hd_v_q && oom) begin
          res_status = STAT_NO_MEMORY;
        end else begin
          class_we  = exec_go;
          head_pop  = exec_go && hd_v_q;
          if (!hd_v_q) begin
            cur_blk_d = blk_sel;
            bump_d    = off_sel + csize;
          end
          res_addr  = 16'(start_a + XW'(HEADER_BYTES));
          res_bytes = cbytes;
        end
      end
      KIND_FREE: begin
        if (bad_q || free_bad_cls) begin
          res_status = STAT_BAD_FREE;
        end else begin
          link_we   = exec_go;
          head_push = exec_go;
          res_addr  = addr_q;
          res_bytes = cbytes;
        end
      end
      KIND_CLEAR: begin
        pool_clear = exec_go;
      end
      KIND_NONE: begin
      end
      default: begin
      end
    endcase
  end

  // Pool registers: block size, bump pointer, list heads
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bl_q      <= BLK_LOG2_W'(BL_RESET);
      cur_blk_q <= '0;
      bump_q    <= '0;
      for (int i = 0; i < NUM_CLASSES; i++) begin
        head_v_q[i] <= 1'b0;
      end
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_block_size_log2_i < 5'd6) begin
        bl_q <= (EFF_MAX < 6) ? BLK_LOG2_W'(EFF_MAX) : 5'd6;
      end else if (cfg_block_size_log2_i > BLK_LOG2_W'(EFF_MAX)) begin
        bl_q <= BLK_LOG2_W'(EFF_MAX);
      end else begin
        bl_q <= cfg_block_size_log2_i;
      end
      cur_blk_q <= '0;
      bump_q    <= '0;
      for (int i = 0; i < NUM_CLASSES; i++) begin
        head_v_q[i] <= 1'b0;
      end
    end else if (pool_clear) begin
      cur_blk_q <= '0;
      bump_q    <= '0;
      for (int i = 0; i < NUM_CLASSES; i++) begin
        head_v_q[i] <= 1'b0;
      end
    end else if (exec_go) begin
      cur_blk_q <= cur_blk_d;
      bump_q    <= bump_d;
      if (head_pop) head_v_q[cls_q] <= link_rd_q[LW-1];
      if (head_push) head_v_q[class_rd_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (head_pop) head_idx_q[cls_q] <= link_rd_q[GW-1:0];
    if (head_push) head_idx_q[class_rd_q] <= gran_q;
  end

  // Output register: load on finish, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (exec_go) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_go) begin
      out_addr_q   <= res_addr;
      out_bytes_q  <= res_bytes;
      out_status_q <= res_status;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign data_address_o = out_addr_q;
  assign chunk_bytes_o  = out_bytes_q;
  assign status_o       = out_status_q;

  // Checks
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_EXEC))
    else $error("request not followed by execute cycle");

  a_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_status_q != STAT_OK)) |-> (out_addr_q == '0 && out_bytes_q == '0))
    else $error("refused result carries nonzero fields");

  a_bytes_pow2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_bytes_q != '0) |-> $onehot(out_bytes_q))
    else $error("chunk size is not a power of two");

  a_bump_in_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (bump_q <= bsize))
    else $error("bump offset past block end");

  a_block_in_arena: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (XW'(cur_blk_q) < nblocks))
    else $error("current block past arena end");

endmodule
